// ----- design/sprite_quad_vertex_setup_defines.svh -----
// assertion macros for the sprite quad vertex setup block
`ifndef SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SQVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SQVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sqvs_pkg.sv -----
// shared types, constants and helpers for the sprite quad vertex setup block
`timescale 1ns / 1ps

package sqvs_pkg;

  typedef enum logic [2:0] {
    REG_SCALE_X     = 3'd0,
    REG_SCALE_Y     = 3'd1,
    REG_OFFSET_X    = 3'd2,
    REG_OFFSET_Y    = 3'd3,
    REG_CLIP_LEFT   = 3'd4,
    REG_CLIP_TOP    = 3'd5,
    REG_CLIP_RIGHT  = 3'd6,
    REG_CLIP_BOTTOM = 3'd7
  } reg_idx_t;

  localparam int CFG_ADDR_W = 5;

  localparam logic [31:0] RST_SCALE       = 32'd65536;
  localparam logic [31:0] RST_CLIP_RIGHT  = 32'd83886080;
  localparam logic [31:0] RST_CLIP_BOTTOM = 32'd47185920;

  localparam logic [14:0] QC_ONE = 15'd16384;
  localparam logic [14:0] QC_K1  = 15'd19900;
  localparam logic [11:0] QC_K2  = 12'd3516;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [58:0] v);
    logic signed [58:0] hi;
    logic signed [58:0] lo;
    hi = 59'sd2147483647;
    lo = -59'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- design/sqvs_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module sqvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/sprite_quad_vertex_setup.sv -----
// sprite quad vertex setup: sprite table, view transform, cull, rotate, emit four vertices
`timescale 1ns / 1ps
`include "sprite_quad_vertex_setup_defines.svh"

// usage
// an item is taken when start is high and busy is low; busy stays high until the
// cycle that presents the item's last result. results come out one per strobe on
// out_valid with out_last marking the final one; the receiver cannot stall, every
// strobe is a transfer.
// a load writes the slot and gives one result, registered out of the check state.
// a rejected item (slot out of range, empty slot, bad layer) gives one result in
// the same way, a culled draw one result after the view transform and cull check.
// a draw that passes runs the view transform, cull, corner offsets, remainder and
// texture steps, then gives four vertices, each through the ea and eb states; a
// new item can be taken in the same cycle as the last vertex is presented. the
// length of a draw is set by the 16-step remainder unit for the frame column and
// by the one shared multiplier used for the view scale, one product per cycle.
// the sprite table sits in two rams with registered read; a valid bit per slot is
// cleared at reset, the ram contents are not.
// configuration goes through the apb port, one 32-bit register per word.
// reset is synchronous, active low, and returns the registers to their defaults.

module sprite_quad_vertex_setup #(
  parameter int SPRITE_SLOTS = 256,
  parameter int LAYERS       = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_mode,
  input  logic [7:0]                           in_sprite_index,
  input  logic signed [31:0]                   in_pos_x,
  input  logic signed [31:0]                   in_pos_y,
  input  logic signed [31:0]                   in_size_x,
  input  logic signed [31:0]                   in_size_y,
  input  logic signed [15:0]                   in_origin_x,
  input  logic signed [15:0]                   in_origin_y,
  input  logic [15:0]                          in_rotation,
  input  logic [15:0]                          in_frame,
  input  logic [31:0]                          in_color,
  input  logic [7:0]                           in_layer,
  output logic                                 out_valid,
  output logic                                 out_accepted,
  output logic [1:0]                           out_corner,
  output logic                                 out_last,
  output logic signed [31:0]                   out_vertex_x,
  output logic signed [31:0]                   out_vertex_y,
  output logic [15:0]                          out_tex_u,
  output logic [15:0]                          out_tex_v,
  output logic [31:0]                          out_vertex_color,
  output logic [7:0]                           out_out_layer,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sqvs_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int IW = $clog2(SPRITE_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_M0, S_M1, S_M2, S_M3, S_M4, S_D, S_CULL,
    S_L0, S_L1, S_L2, S_L3, S_DIV, S_TEX, S_EA, S_EB
  } state_t;

  state_t state_r;

  // configuration registers
  logic signed [31:0] scale_x_r, scale_y_r, offset_x_r, offset_y_r;
  logic signed [31:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic               cfg_wr;
  sqvs_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = sqvs_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r     <= sqvs_pkg::RST_SCALE;
      scale_y_r     <= sqvs_pkg::RST_SCALE;
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= sqvs_pkg::RST_CLIP_RIGHT;
      clip_bottom_r <= sqvs_pkg::RST_CLIP_BOTTOM;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sqvs_pkg::REG_SCALE_X:     scale_x_r     <= pwdata;
        sqvs_pkg::REG_SCALE_Y:     scale_y_r     <= pwdata;
        sqvs_pkg::REG_OFFSET_X:    offset_x_r    <= pwdata;
        sqvs_pkg::REG_OFFSET_Y:    offset_y_r    <= pwdata;
        sqvs_pkg::REG_CLIP_LEFT:   clip_left_r   <= pwdata;
        sqvs_pkg::REG_CLIP_TOP:    clip_top_r    <= pwdata;
        sqvs_pkg::REG_CLIP_RIGHT:  clip_right_r  <= pwdata;
        sqvs_pkg::REG_CLIP_BOTTOM: clip_bottom_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sqvs_pkg::REG_SCALE_X:     prdata = scale_x_r;
      sqvs_pkg::REG_SCALE_Y:     prdata = scale_y_r;
      sqvs_pkg::REG_OFFSET_X:    prdata = offset_x_r;
      sqvs_pkg::REG_OFFSET_Y:    prdata = offset_y_r;
      sqvs_pkg::REG_CLIP_LEFT:   prdata = clip_left_r;
      sqvs_pkg::REG_CLIP_TOP:    prdata = clip_top_r;
      sqvs_pkg::REG_CLIP_RIGHT:  prdata = clip_right_r;
      sqvs_pkg::REG_CLIP_BOTTOM: prdata = clip_bottom_r;
      default:                   prdata = '0;
    endcase
  end

  // captured item
  logic               mode_r;
  logic [7:0]         idx_r;
  logic signed [31:0] pos_x_r, pos_y_r, size_x_r, size_y_r;
  logic signed [15:0] origin_x_r, origin_y_r;
  logic [15:0]        rot_r, frame_r;
  logic [31:0]        color_r;
  logic [7:0]         layer_r;

  // sprite table
  logic [IW-1:0] slot;
  logic          ram_we;
  logic [31:0]   atlas_rd;
  logic [47:0]   geom_rd;
  logic [SPRITE_SLOTS-1:0] valid_r;

  assign slot   = IW'(idx_r);
  assign ram_we = (state_r == S_CHK) && !mode_r && (32'(idx_r) < 32'(SPRITE_SLOTS));

  sqvs_ram #(.WIDTH(32), .DEPTH(SPRITE_SLOTS)) u_atlas_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({pos_y_r[15:0], pos_x_r[15:0]}),
    .raddr (IW'(in_sprite_index)),
    .rdata (atlas_rd)
  );

  sqvs_ram #(.WIDTH(48), .DEPTH(SPRITE_SLOTS)) u_geom_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({frame_r, size_y_r[15:0], size_x_r[15:0]}),
    .raddr (IW'(in_sprite_index)),
    .rdata (geom_rd)
  );

  logic in_range, layer_ok, chk_fail;
  assign in_range = 32'(idx_r) < 32'(SPRITE_SLOTS);
  assign layer_ok = {1'b0, layer_r} < 9'(LAYERS);
  assign chk_fail = !in_range || (mode_r && (!valid_r[slot] || !layer_ok));

  // trig pipeline, registers z, inner, q and then c/s from the captured rotation
  logic [15:0]        ang;
  logic [14:0]        tf, tg;
  logic [29:0]        ttf, ttg;
  logic [14:0]        zf_r, zg_r, innerf_r, innerg_r, qf_r, qg_r;
  logic [26:0]        kf, kg;
  logic [29:0]        mf, mg;
  logic signed [15:0] c_r, s_r;
  logic signed [15:0] qfs, qgs;

  assign ang = 16'd0 - rot_r;
  assign tf  = {1'b0, ang[13:0]};
  assign tg  = sqvs_pkg::QC_ONE - tf;
  assign ttf = tf * tf;
  assign ttg = tg * tg;
  assign kf  = zf_r * 27'(sqvs_pkg::QC_K2);
  assign kg  = zg_r * 27'(sqvs_pkg::QC_K2);
  assign mf  = zf_r * innerf_r;
  assign mg  = zg_r * innerg_r;
  assign qfs = {1'b0, qf_r};
  assign qgs = {1'b0, qg_r};

  always_ff @(posedge clk) begin
    zf_r     <= ttf[28:14];
    zg_r     <= ttg[28:14];
    innerf_r <= sqvs_pkg::QC_K1 - {2'b00, kf[26:14]};
    innerg_r <= sqvs_pkg::QC_K1 - {2'b00, kg[26:14]};
    qf_r     <= sqvs_pkg::QC_ONE - mf[28:14];
    qg_r     <= sqvs_pkg::QC_ONE - mg[28:14];
    case (ang[15:14])
      2'd0: begin
        c_r <= qfs;
        s_r <= qgs;
      end
      2'd1: begin
        c_r <= -qgs;
        s_r <= qfs;
      end
      2'd2: begin
        c_r <= -qfs;
        s_r <= -qgs;
      end
      default: begin
        c_r <= qgs;
        s_r <= -qfs;
      end
    endcase
  end

  // shared view multiplier
  logic signed [32:0] sxe, sye, sxa, sya, mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mprod, p_r, pround;
  logic signed [49:0] rnd50, offx50, offy50;

  assign sxe = {scale_x_r[31], scale_x_r};
  assign sye = {scale_y_r[31], scale_y_r};
  assign sxa = sxe[32] ? -sxe : sxe;
  assign sya = sye[32] ? -sye : sye;

  always_comb begin
    case (state_r)
      S_M1: begin
        mul_a = sye;
        mul_b = pos_y_r;
      end
      S_M2: begin
        mul_a = sxa;
        mul_b = size_x_r;
      end
      S_M3: begin
        mul_a = sya;
        mul_b = size_y_r;
      end
      default: begin
        mul_a = sxe;
        mul_b = pos_x_r;
      end
    endcase
  end

  assign mprod  = mul_a * mul_b;
  assign pround = p_r + 65'sd32768;
  assign rnd50  = $signed(pround[64:16]);
  assign offx50 = offset_x_r;
  assign offy50 = offset_y_r;

  // geometry
  logic signed [49:0] px_r, py_r, w_r, h_r;
  logic signed [50:0] wa, ha, d_r;
  logic signed [52:0] xp, xm, yp, ym;
  logic               culled;

  assign wa     = w_r[49] ? -w_r : w_r;
  assign ha     = h_r[49] ? -h_r : h_r;
  assign xp     = px_r + d_r;
  assign xm     = px_r - d_r;
  assign yp     = py_r + d_r;
  assign ym     = py_r - d_r;
  assign culled = (xp < clip_left_r) || (yp < clip_top_r) ||
                  (xm > clip_right_r) || (ym > clip_bottom_r);

  // corner offsets, one product per step
  logic signed [17:0] oxe, oye, lfac;
  logic signed [49:0] llen;
  logic signed [67:0] lprod, lround;
  logic signed [54:0] lval, lx0_r, lx1_r, ly0_r, ly1_r;

  assign oxe = origin_x_r;
  assign oye = origin_y_r;

  always_comb begin
    case (state_r)
      S_L1: begin
        llen = w_r;
        lfac = 18'sd16384 - oxe;
      end
      S_L2: begin
        llen = h_r;
        lfac = 18'sd0 - oye;
      end
      S_L3: begin
        llen = h_r;
        lfac = 18'sd16384 - oye;
      end
      default: begin
        llen = w_r;
        lfac = 18'sd0 - oxe;
      end
    endcase
  end

  assign lprod  = llen * lfac;
  assign lround = lprod + 68'sd8192;
  assign lval   = $signed(lround[67:14]);

  // frame column remainder, one bit per cycle
  logic [15:0] ax_r, ay_r, fw_r, fh_r, cnt_r;
  logic [15:0] rem_r, dvd_r, u0_r;
  logic [3:0]  bit_r;
  logic [16:0] r2;
  logic [16:0] r2sub;
  logic [15:0] rem_nxt;
  logic [31:0] fwrem;

  assign r2      = {rem_r, dvd_r[15]};
  assign r2sub   = r2 - {1'b0, cnt_r};
  assign rem_nxt = (r2 >= {1'b0, cnt_r}) ? r2sub[15:0] : r2[15:0];
  assign fwrem   = fw_r * rem_r;

  // corner emission
  logic [1:0]         k_r;
  logic               xi, yi;
  logic signed [54:0] lxs, lys;
  logic signed [15:0] ns;
  logic signed [70:0] ea_r, eb_r, ec_r, ed_r;
  logic signed [71:0] sumx, sumy;
  logic signed [58:0] fx, fy;

  assign xi   = (k_r == 2'd1) || (k_r == 2'd2);
  assign yi   = k_r[1];
  assign lxs  = xi ? lx1_r : lx0_r;
  assign lys  = yi ? ly1_r : ly0_r;
  assign ns   = -s_r;
  assign sumx = ea_r + eb_r + 72'sd8192;
  assign sumy = ec_r + ed_r + 72'sd8192;
  assign fx   = $signed(sumx[71:14]) + px_r;
  assign fy   = $signed(sumy[71:14]) + py_r;

  // result registers
  logic               out_valid_r, out_accepted_r, out_last_r;
  logic [1:0]         out_corner_r;
  logic signed [31:0] out_vertex_x_r, out_vertex_y_r;
  logic [15:0]        out_tex_u_r, out_tex_v_r;
  logic [31:0]        out_vertex_color_r;
  logic [7:0]         out_layer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r     <= in_mode;
            idx_r      <= in_sprite_index;
            pos_x_r    <= in_pos_x;
            pos_y_r    <= in_pos_y;
            size_x_r   <= in_size_x;
            size_y_r   <= in_size_y;
            origin_x_r <= in_origin_x;
            origin_y_r <= in_origin_y;
            rot_r      <= in_rotation;
            frame_r    <= in_frame;
            color_r    <= in_color;
            layer_r    <= in_layer;
            state_r    <= S_CHK;
          end
        end
        S_CHK: begin
          ax_r  <= atlas_rd[15:0];
          ay_r  <= atlas_rd[31:16];
          fw_r  <= geom_rd[15:0];
          fh_r  <= geom_rd[31:16];
          cnt_r <= (geom_rd[47:32] == 16'd0) ? 16'd1 : geom_rd[47:32];
          if (chk_fail || !mode_r) begin
            if (!chk_fail) begin
              valid_r[slot] <= 1'b1;
            end
            out_valid_r        <= 1'b1;
            out_accepted_r     <= !chk_fail;
            out_last_r         <= 1'b1;
            out_corner_r       <= sqvs_pkg::CORNER_FIRST;
            out_vertex_x_r     <= '0;
            out_vertex_y_r     <= '0;
            out_tex_u_r        <= '0;
            out_tex_v_r        <= '0;
            out_vertex_color_r <= '0;
            out_layer_r        <= '0;
            state_r            <= S_IDLE;
          end else begin
            state_r <= S_M0;
          end
        end
        S_M0: begin
          p_r     <= mprod;
          state_r <= S_M1;
        end
        S_M1: begin
          px_r    <= rnd50 + offx50;
          p_r     <= mprod;
          state_r <= S_M2;
        end
        S_M2: begin
          py_r    <= rnd50 + offy50;
          p_r     <= mprod;
          state_r <= S_M3;
        end
        S_M3: begin
          w_r     <= rnd50;
          p_r     <= mprod;
          state_r <= S_M4;
        end
        S_M4: begin
          h_r     <= rnd50;
          state_r <= S_D;
        end
        S_D: begin
          d_r     <= wa + ha;
          state_r <= S_CULL;
        end
        S_CULL: begin
          if (culled) begin
            out_valid_r        <= 1'b1;
            out_accepted_r     <= 1'b0;
            out_last_r         <= 1'b1;
            out_corner_r       <= sqvs_pkg::CORNER_FIRST;
            out_vertex_x_r     <= '0;
            out_vertex_y_r     <= '0;
            out_tex_u_r        <= '0;
            out_tex_v_r        <= '0;
            out_vertex_color_r <= '0;
            out_layer_r        <= '0;
            state_r            <= S_IDLE;
          end else begin
            state_r <= S_L0;
          end
        end
        S_L0: begin
          lx0_r   <= lval;
          state_r <= S_L1;
        end
        S_L1: begin
          lx1_r   <= lval;
          state_r <= S_L2;
        end
        S_L2: begin
          ly0_r   <= lval;
          state_r <= S_L3;
        end
        S_L3: begin
          ly1_r   <= lval;
          rem_r   <= '0;
          dvd_r   <= frame_r;
          bit_r   <= 4'd15;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[14:0], 1'b0};
          bit_r <= bit_r - 4'd1;
          if (bit_r == 4'd0) begin
            state_r <= S_TEX;
          end
        end
        S_TEX: begin
          u0_r    <= ax_r + fwrem[15:0];
          k_r     <= sqvs_pkg::CORNER_FIRST;
          state_r <= S_EA;
        end
        S_EA: begin
          ea_r    <= c_r * lxs;
          eb_r    <= s_r * lys;
          ec_r    <= ns * lxs;
          ed_r    <= c_r * lys;
          state_r <= S_EB;
        end
        S_EB: begin
          out_valid_r        <= 1'b1;
          out_accepted_r     <= 1'b1;
          out_last_r         <= (k_r == sqvs_pkg::CORNER_LAST);
          out_corner_r       <= k_r;
          out_vertex_x_r     <= sqvs_pkg::sat32(fx);
          out_vertex_y_r     <= sqvs_pkg::sat32(fy);
          out_tex_u_r        <= u0_r + (xi ? fw_r : 16'd0);
          out_tex_v_r        <= ay_r + (yi ? fh_r : 16'd0);
          out_vertex_color_r <= color_r;
          out_layer_r        <= layer_r;
          if (k_r == sqvs_pkg::CORNER_LAST) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_EA;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_corner       = out_corner_r;
  assign out_last         = out_last_r;
  assign out_vertex_x     = out_vertex_x_r;
  assign out_vertex_y     = out_vertex_y_r;
  assign out_tex_u        = out_tex_u_r;
  assign out_tex_v        = out_tex_v_r;
  assign out_vertex_color = out_vertex_color_r;
  assign out_out_layer    = out_layer_r;

  `SQVS_ASSERT_NOW(a_mid_vertex_accepted, out_valid && !out_last, out_accepted, "non-final result not a vertex")
  `SQVS_ASSERT_NOW(a_mid_vertex_busy, out_valid && !out_last, busy, "idle with vertices pending")
  `SQVS_ASSERT_NEXT(a_last_gap, out_valid && out_last, !out_valid, "result right after a final result")
  `SQVS_ASSERT_NEXT(a_take_busy, start && !busy, busy, "transfer did not start work")

endmodule
